// ===== hdl/ffd_pkg.sv =====
// Shared widths, register map, controller command types and saturation helper.
package ffd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int DELAY_W        = 23;
    localparam int FRAC_W         = 8;
    localparam int DELAY_INT_W    = DELAY_W - FRAC_W;
    localparam int MIX_W          = 16;
    localparam int GAIN_W         = 16;
    localparam int SAT_W          = 20;

    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 4;
    localparam int REG_IDX_W      = 2;

    localparam logic [REG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WET_MIX       = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 23'd256;
    localparam logic [MIX_W-1:0]   WET_RESET   = 16'd16384;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd0;

    // Q1.15 unity for the mix coefficients
    localparam logic [MIX_W-1:0]   UNITY       = 16'd32768;

    localparam int STORE_DEPTH_DEFAULT = 32768;

    typedef struct packed {
        logic load;      // input transfer: latch sample and read addresses
        logic rd_i2;     // read port addresses the second neighbor
        logic cap_s1;    // first neighbor is on the read data
        logic diff;      // neighbor difference
        logic mul1;      // fraction times difference
        logic interp;    // delayed sample
        logic mul2;      // feedback, wet and dry products
        logic commit;    // store write, pointer advance, result
        logic clear;     // clearing pass write
        logic out_load;  // result into output register
    } ffd_cmd_t;

    typedef struct packed {
        logic ptr_last;  // write pointer at last entry
        logic out_free;  // output register can take a result
    } ffd_sts_t;

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > $signed(SAT_W'(32767)))
            r = 16'sh7FFF;
        else if (v < -$signed(SAT_W'(32768)))
            r = 16'sh8000;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/ffd_regs.sv =====
// APB register file and delay-length modulo reduction unit.
module ffd_regs
    import ffd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
    localparam int PW = $clog2(STORE_DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output logic [PW-1:0]          delay_int,
    output logic [FRAC_W-1:0]      delay_frac,
    output logic [MIX_W-1:0]       wet_eff,
    output logic [GAIN_W-1:0]      gain,
    output logic                   busy
);

    localparam int RW = ((PW > DELAY_INT_W) ? PW : DELAY_INT_W) + 1;
    // floor(v / STORE_DEPTH) for any integer delay v: (v * RECIP) >> RSH
    localparam int RSH = DELAY_INT_W + PW;
    localparam int MW  = DELAY_INT_W + 2;
    localparam int PRW = DELAY_INT_W + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << RSH) + longint'(STORE_DEPTH) - 1) / longint'(STORE_DEPTH));
    // quotient is zero whenever the depth does not fit here
    localparam logic [DELAY_INT_W-1:0] DEPTH_LO = DELAY_INT_W'(STORE_DEPTH);
    localparam logic [RW-1:0] INT_RESET =
        RW'((int'(DELAY_RESET) >> FRAC_W) % STORE_DEPTH);

    logic [DELAY_W-1:0]     delay_reg;
    logic [MIX_W-1:0]       wet_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [RW-1:0]          rem_reg;
    logic [DELAY_INT_W-1:0] val_reg;
    logic [DELAY_INT_W-1:0] quo_reg;
    logic                   busy_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   idx;
    logic [DELAY_INT_W-1:0] wr_int;
    logic [PRW-1:0]         recip_prod;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    assign wr_int     = pwdata[DELAY_W-1:FRAC_W];
    assign recip_prod = PRW'(wr_int) * PRW'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            wet_reg   <= WET_RESET;
            gain_reg  <= GAIN_RESET;
            rem_reg   <= INT_RESET;
            val_reg   <= '0;
            quo_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && idx == REG_DELAY_LENGTH)
            begin
                delay_reg <= pwdata[DELAY_W-1:0];
                val_reg   <= wr_int;
                quo_reg   <= DELAY_INT_W'(recip_prod >> RSH);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                // remainder from the quotient, in the cycle after the write
                rem_reg  <= RW'(val_reg - DELAY_INT_W'(quo_reg * DEPTH_LO));
                busy_reg <= 1'b0;
            end
            if (wr_en && idx == REG_WET_MIX)
                wet_reg <= pwdata[MIX_W-1:0];
            if (wr_en && idx == REG_FEEDBACK_GAIN)
                gain_reg <= pwdata[GAIN_W-1:0];
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DELAY_LENGTH:  prdata = APB_DATA_W'(delay_reg);
            REG_WET_MIX:       prdata = APB_DATA_W'(wet_reg);
            REG_FEEDBACK_GAIN: prdata = APB_DATA_W'(gain_reg);
            default:           prdata = '0;
        endcase
    end

    assign delay_int  = rem_reg[PW-1:0];
    assign delay_frac = delay_reg[FRAC_W-1:0];
    assign wet_eff    = (wet_reg > UNITY) ? UNITY : wet_reg;
    assign gain       = gain_reg;
    assign busy       = busy_reg;

endmodule

// ===== hdl/ffd_ctrl.sv =====
// Sequencing state machine: clearing pass, then one item through the datapath.
module ffd_ctrl
    import ffd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      cfg_busy,
    input  ffd_sts_t  sts,
    output logic      in_stall,
    output ffd_cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD1    = 4'd2;
    localparam logic [3:0] S_RD2    = 4'd3;
    localparam logic [3:0] S_DIFF   = 4'd4;
    localparam logic [3:0] S_MUL1   = 4'd5;
    localparam logic [3:0] S_INTERP = 4'd6;
    localparam logic [3:0] S_MUL2   = 4'd7;
    localparam logic [3:0] S_COMMIT = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE) || cfg_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.ptr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RD1:
                state_next = S_RD2;
            S_RD2:
            begin
                cmd.rd_i2  = 1'b1;
                cmd.cap_s1 = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.interp = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

endmodule

// ===== hdl/ffd_dp.sv =====
// Datapath: delay store, write pointer, interpolation, feedback and mix, output register.
module ffd_dp
    import ffd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT,
    localparam int PW = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffd_cmd_t                    cmd,
    output ffd_sts_t                    sts,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic [PW-1:0]               delay_int,
    input  logic [FRAC_W-1:0]           delay_frac,
    input  logic [MIX_W-1:0]            wet_eff,
    input  logic [GAIN_W-1:0]           gain,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic signed [SAMPLE_W-1:0]  sample_out
);

    localparam logic [PW-1:0] LAST = PW'(STORE_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X = (PW + 1)'(STORE_DEPTH);

    logic signed [SAMPLE_W-1:0]  mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0]  rd_data_reg;

    logic [PW-1:0]               wp_reg;
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_data_reg;

    logic signed [SAMPLE_W-1:0]  x_reg;
    logic [PW-1:0]               i1_reg;
    logic [FRAC_W-1:0]           f_reg;
    logic signed [SAMPLE_W-1:0]  s1_reg;
    logic signed [SAMPLE_W:0]    diff_reg;
    logic signed [SAMPLE_W+FRAC_W+1:0] prod_reg;
    logic signed [SAMPLE_W-1:0]  d_reg;
    logic signed [2*SAMPLE_W-1:0] fbp_reg;
    logic signed [2*SAMPLE_W:0]  wetp_reg;
    logic signed [2*SAMPLE_W:0]  dryp_reg;
    logic signed [SAMPLE_W-1:0]  res_reg;

    logic [PW:0]                 rel;
    logic [PW:0]                 rel_wrap;
    logic [PW-1:0]               i1_calc;
    logic [PW-1:0]               i2;
    logic [PW-1:0]               rd_addr;
    logic [PW-1:0]               wp_next;
    logic                        mem_we;
    logic signed [SAMPLE_W-1:0]  mem_wdata;
    logic signed [SAMPLE_W+1:0]  interp_sum;
    logic signed [SAMPLE_W+1:0]  store_sum;
    logic signed [2*SAMPLE_W+1:0] mix_sum;
    logic [MIX_W-1:0]            dry_coef;

    // read position: pointer minus delay, one entry further back on a fraction
    assign rel      = {1'b0, wp_reg} - {1'b0, delay_int} - (PW + 1)'(|delay_frac);
    assign rel_wrap = rel + DEPTH_X;
    assign i1_calc  = rel[PW] ? rel_wrap[PW-1:0] : rel[PW-1:0];
    assign i2       = (i1_reg == LAST) ? '0 : i1_reg + 1'b1;
    assign rd_addr  = cmd.rd_i2 ? i2 : i1_reg;
    assign wp_next  = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;

    assign interp_sum = $signed({{2{s1_reg[SAMPLE_W-1]}}, s1_reg})
                      + $signed(prod_reg[SAMPLE_W+FRAC_W+1:FRAC_W]);
    assign store_sum  = $signed({{2{x_reg[SAMPLE_W-1]}}, x_reg})
                      + $signed({fbp_reg[2*SAMPLE_W-1], fbp_reg[2*SAMPLE_W-1:15]});
    assign mix_sum    = $signed({wetp_reg[2*SAMPLE_W], wetp_reg})
                      + $signed({dryp_reg[2*SAMPLE_W], dryp_reg});
    assign dry_coef   = UNITY - wet_eff;

    assign mem_we    = cmd.clear || cmd.commit;
    assign mem_wdata = cmd.clear ? '0
                     : sat16(SAT_W'(store_sum));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
                wp_reg <= wp_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= sample_in;
            i1_reg <= i1_calc;
            f_reg  <= FRAC_W'(0) - delay_frac;
        end
        if (cmd.cap_s1)
            s1_reg <= rd_data_reg;
        if (cmd.diff)
            diff_reg <= $signed({rd_data_reg[SAMPLE_W-1], rd_data_reg})
                      - $signed({s1_reg[SAMPLE_W-1], s1_reg});
        if (cmd.mul1)
            prod_reg <= $signed({1'b0, f_reg}) * diff_reg;
        if (cmd.interp)
            d_reg <= interp_sum[SAMPLE_W-1:0];
        if (cmd.mul2)
        begin
            fbp_reg  <= d_reg * $signed(gain);
            wetp_reg <= d_reg * $signed({1'b0, wet_eff});
            dryp_reg <= x_reg * $signed({1'b0, dry_coef});
        end
        if (cmd.commit)
            res_reg <= sat16(SAT_W'($signed(mix_sum[2*SAMPLE_W+1:15])));
        if (cmd.out_load)
            out_data_reg <= res_reg;
    end

    assign sts.ptr_last = (wp_reg == LAST);
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign sample_out   = out_data_reg;

endmodule

// ===== hdl/fractional_feedback_delay_core.sv =====
// Top level of the fractional feedback delay line.
// Usage:
//   Input channel (in_valid / in_stall / sample_in) takes one signed Q1.15
//   sample per transfer. Output channel (out_valid / out_stall / sample_out)
//   returns exactly one mixed sample per input transfer, in order. APB port
//   holds delay_length (0x0, 8 fraction bits), wet_mix (0x4) and feedback_gain
//   (0x8); the user writes only while idle; the block does not enforce it.
// Timing:
//   An item runs from its input transfer to its result entering the output
//   register through the sequencer states: two reads of the single store read
//   port, difference, interpolation multiply and sum, the feedback and mix
//   multiplies, then the store write. The next input transfer is taken in the
//   cycle after the result is registered, so only one item runs at a time.
//   A delay_length write holds in_stall high for one cycle while the integer
//   delay is reduced modulo the store depth.
// Reset and stall:
//   Control clears at once, then a clearing pass zeroes all STORE_DEPTH
//   entries, one per cycle, with in_stall high; APB writes are still taken.
//   A stalled result holds in the output register; one more item can run up
//   to its result, then waits for the register.
module fractional_feedback_delay_core
    import ffd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  sample_out
);

    localparam int PW = $clog2(STORE_DEPTH);

    logic [PW-1:0]      delay_int;
    logic [FRAC_W-1:0]  delay_frac;
    logic [MIX_W-1:0]   wet_eff;
    logic [GAIN_W-1:0]  gain;
    logic               cfg_busy;
    ffd_cmd_t           cmd;
    ffd_sts_t           sts;

    // configuration registers; delay integer part reduced modulo depth
    ffd_regs #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .delay_int  (delay_int),
        .delay_frac (delay_frac),
        .wet_eff    (wet_eff),
        .gain       (gain),
        .busy       (cfg_busy)
    );

    // sequencer
    ffd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_busy (cfg_busy),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // store, arithmetic and output register
    ffd_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .sample_in  (sample_in),
        .delay_int  (delay_int),
        .delay_frac (delay_frac),
        .wet_eff    (wet_eff),
        .gain       (gain),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

endmodule

// ===== tb/sv/tb_fractional_feedback_delay_core.sv =====
// Self-checking testbench for the fractional feedback delay core: directed table, then random traffic.
module tb_fractional_feedback_delay_core;
    import ffd_pkg::*;

    localparam int DEPTH       = STORE_DEPTH_DEFAULT;
    // Slowest correct run: the clearing pass over every store entry, plus ~1800
    // items, each behind the longest sender gap and receiver stall, plus the
    // long hold-off.
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 150;     // long receiver hold-off
    localparam int TAIL_CYCLES = 40;      // quiet time after the last result
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 178;
    localparam int PLAN_LEN    = 25;

    // index with no register behind it; writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_e;

    // One row of the directed table: either a register write or a sample.
    // Rows with typed set carry a hand-worked result instead of the predicted one.
    typedef struct packed {
        step_kind_e                 kind;
        logic [REG_IDX_W-1:0]       reg_idx;
        logic [APB_DATA_W-1:0]      value;
        logic signed [SAMPLE_W-1:0] x_in;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want;
    } step_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]       paddr    = '0;
    logic [APB_DATA_W-1:0]       pwdata   = '0;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample_in = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample_out;

    // ------------------------------------------------------------------
    // Predictor state: delay line contents, write pointer, register shadows
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0]  line_mem [DEPTH];
    int                          line_wr   = 0;
    logic [DELAY_W-1:0]          cfg_delay = DELAY_RESET;
    logic [MIX_W-1:0]            cfg_wet   = WET_RESET;
    logic signed [GAIN_W-1:0]    cfg_fb    = GAIN_RESET;

    // mixed samples still owed by the block, oldest first
    logic signed [SAMPLE_W-1:0]  pending_mix [$];

    int   mismatches  = 0;
    int   cycle_count = 0;
    bit   tx_bursty   = 1'b1;   // sender inserts idle gaps
    bit   rx_calm     = 1'b0;   // receiver never stalls
    bit   hold_req    = 1'b0;   // request for the long receiver hold-off

    // Directed table. Reset state: one-sample delay, half wet, no feedback.
    step_t plan [PLAN_LEN] = '{
        // half wet, empty line: output is half the input, rounded down
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd32767,  1'b1, 16'sd16383},
        // delayed 32767 against -32768 at half mix: -0.5 floors to -1
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sh8000,   1'b1, 16'shFFFF},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd0,      1'b1, -16'sd16384},
        // fully wet: the previous stored sample (zero) comes straight out
        '{STEP_WRITE,  REG_WET_MIX,       32'd32768,    16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd1234,   1'b1, 16'sd0},
        // fully dry: input passes through
        '{STEP_WRITE,  REG_WET_MIX,       32'd0,        16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'shFFFF,   1'b1, 16'shFFFF},
        // wet above one clamps to fully wet; returns the -1 stored just before
        '{STEP_WRITE,  REG_WET_MIX,       32'h0000FFFF, 16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd5,      1'b1, 16'shFFFF},
        // zero delay reads the entry before it is overwritten (never written: zero)
        '{STEP_WRITE,  REG_DELAY_LENGTH,  32'd0,        16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd100,    1'b1, 16'sd0},
        // longest delay: read position wraps around the whole store
        '{STEP_WRITE,  REG_DELAY_LENGTH,  32'h007FFFFF, 16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd7,      1'b0, 16'sd0},
        // strongest positive feedback drives the stored value into saturation
        '{STEP_WRITE,  REG_FEEDBACK_GAIN, 32'h00007FFF, 16'sd0,      1'b0, 16'sd0},
        '{STEP_WRITE,  REG_DELAY_LENGTH,  32'd256,      16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd32767,  1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd32767,  1'b0, 16'sd0},
        // strongest negative feedback, negative saturation
        '{STEP_WRITE,  REG_FEEDBACK_GAIN, 32'h00008000, 16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sh8000,   1'b0, 16'sd0},
        // 1.5 samples: interpolation halfway between neighbors
        '{STEP_WRITE,  REG_DELAY_LENGTH,  32'd384,      16'sd0,      1'b0, 16'sd0},
        '{STEP_WRITE,  REG_WET_MIX,       32'd16384,    16'sd0,      1'b0, 16'sd0},
        // write to an unmapped index is dropped
        '{STEP_WRITE,  REG_SPARE,         32'hFFFFFFFF, 16'sd0,      1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd12345,  1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        -16'sd20000, 1'b0, 16'sd0},
        '{STEP_SAMPLE, REG_DELAY_LENGTH,  32'd0,        16'sd32767,  1'b0, 16'sd0}
    };

    fractional_feedback_delay_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return SAMPLE_W'(v);
    endfunction

    // Runs one sample through the delay line model and returns the mixed output.
    function automatic logic signed [SAMPLE_W-1:0] predict_mix(
        input logic signed [SAMPLE_W-1:0] x);
        longint span, pos, s1, s2, d, m, acc;
        int     i1, i2;
        span = longint'(DEPTH) << FRAC_W;
        // read position trails the write pointer by delay/256 samples, mod store
        pos  = (longint'(line_wr) << FRAC_W) + span - (longint'(cfg_delay) % span);
        if (pos >= span)
            pos -= span;
        i1 = int'(pos >>> FRAC_W);
        i2 = (i1 + 1) % DEPTH;
        s1 = line_mem[i1];
        s2 = line_mem[i2];
        // linear interpolation, truncated toward minus infinity
        d  = s1 + (((pos & ((1 << FRAC_W) - 1)) * (s2 - s1)) >>> FRAC_W);
        // read happens before the write, so zero delay sees the old entry
        line_mem[line_wr] = clip_sample(longint'(x) + ((d * longint'(cfg_fb)) >>> 15));
        line_wr = (line_wr + 1) % DEPTH;
        m   = (cfg_wet > UNITY) ? longint'(UNITY) : longint'(cfg_wet);
        acc = (longint'(x) * (longint'(UNITY) - m) + d * m) >>> 15;
        return clip_sample(acc);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on %s at cycle %0d: got %0d, wanted %0d",
                 what, cycle_count, got, want);
    endtask

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly short delays so feedback meets freshly written data
    function automatic logic [APB_DATA_W-1:0] pick_delay();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return APB_DATA_W'({DELAY_W{1'b1}});
            2:       return APB_DATA_W'($urandom_range(1, 64) << FRAC_W);
            3, 4:    return APB_DATA_W'($urandom_range(0, (48 << FRAC_W) + 255));
            5:       return APB_DATA_W'($urandom_range(0, 2000 << FRAC_W));
            6:       return $urandom;   // bits above the field ride along
            default: return APB_DATA_W'($urandom_range(256, 767));
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] pick_wet();
        logic [APB_DATA_W-1:0] junk;
        junk = $urandom;
        case ($urandom_range(0, 5))
            0:       return {junk[APB_DATA_W-1:MIX_W], 16'd0};
            1:       return {junk[APB_DATA_W-1:MIX_W], UNITY};
            2:       return {junk[APB_DATA_W-1:MIX_W], 16'hFFFF};
            default: return {junk[APB_DATA_W-1:MIX_W], 16'($urandom)};
        endcase
    endfunction

    function automatic logic [APB_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h00008000;
            1:       return 32'h00007FFF;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks; each is entered and left at a falling edge
    // ------------------------------------------------------------------

    // Register write, then a read back of the same register (unless unmapped).
    task automatic apb_program(input logic [REG_IDX_W-1:0] idx,
                               input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] got, want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_DELAY_LENGTH:  cfg_delay = value[DELAY_W-1:0];
            REG_WET_MIX:       cfg_wet   = value[MIX_W-1:0];
            REG_FEEDBACK_GAIN: cfg_fb    = value[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        if (idx != REG_SPARE)
        begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            got  = '0;
            want = '0;
            case (idx)
                REG_DELAY_LENGTH:
                begin
                    got  = prdata[DELAY_W-1:0];
                    want = cfg_delay;
                end
                REG_WET_MIX:
                begin
                    got  = prdata[MIX_W-1:0];
                    want = cfg_wet;
                end
                REG_FEEDBACK_GAIN:
                begin
                    got  = prdata[GAIN_W-1:0];
                    want = cfg_fb[GAIN_W-1:0];
                end
                default: ;
            endcase
            if (got !== want)
                report_mismatch("register read back", int'(got), int'(want));
            @(negedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one sample, optionally after an idle burst; the prediction is
    // queued at the edge where the transfer happens.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic typed,
                               input logic signed [SAMPLE_W-1:0] want);
        logic signed [SAMPLE_W-1:0] predicted;
        if (tx_bursty && $urandom_range(0, 3) == 0)
        begin
            in_valid  <= 1'b0;
            sample_in <= SAMPLE_W'($urandom);   // payload is don't-care while idle
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (in_stall);
        predicted = predict_mix(x);
        pending_mix.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Stops offering and waits until every owed result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_mix.size() == 0)
                report_mismatch("unrequested sample_out", int'(sample_out), 0);
            else
            begin
                want = pending_mix.pop_front();
                if (sample_out !== want)
                    report_mismatch("sample_out", int'(sample_out), int'(want));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int k, n, ph;
        foreach (line_mem[i])
            line_mem[i] = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. The clearing pass after reset simply shows up as a
        // long input stall on the first transfer.
        for (k = 0; k < PLAN_LEN; k++)
        begin
            if (plan[k].kind == STEP_WRITE)
            begin
                wait_drained();
                apb_program(plan[k].reg_idx, plan[k].value);
            end
            else
                send_sample(plan[k].x_in, plan[k].typed, plan[k].want);
        end

        // Random phases, each with its own register setting. Phases 1, 4, 7
        // and the last one run without idling on either side.
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            tx_bursty = (ph % 3 != 1) && (ph != PHASES - 1);
            rx_calm   = (ph % 3 == 1) || (ph == PHASES - 1);
            apb_program(REG_DELAY_LENGTH, pick_delay());
            apb_program(REG_WET_MIX, pick_wet());
            apb_program(REG_FEEDBACK_GAIN, pick_gain());
            if (ph % 4 == 2)
                apb_program(REG_SPARE, $urandom);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Back-pressure: receiver holds off while samples keep coming,
                // so the block fills and stalls its input. Afterwards the
                // sender waits for everything owed before carrying on.
                if (ph == 3 && n == 0)
                begin
                    tx_bursty = 1'b0;
                    hold_req  = 1'b1;
                end
                if (ph == 3 && n == 30)
                begin
                    wait_drained();
                    tx_bursty = 1'b1;
                end
                send_sample(pick_sample(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
